// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("allocator assertion failed");

// Check that a condition is followed by a result on the next edge.
`define ASSERT_NEXT(label, cond, nxt) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
    else $error("allocator sequence assertion failed");

`endif

// ----- rtl/alc_pkg.sv -----
// ----------------------------------------------------------------------------
// Allocator package
// Field widths, codes and shared types of the block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package alc_pkg;

  localparam int KIND_W         = 2;
  localparam int OFF_W          = 17;
  localparam int COUNT_W        = 9;
  localparam int WORDS_W        = 7;
  localparam int HEADER_BYTES   = 8;
  localparam int WORDS_MAX      = 64;
  localparam int MAX_BLOCKS_DEF = 256;
  localparam int WORD_BYTES_DEF = 8;
  localparam int QUEUE_DEPTH    = 2;
  localparam int APB_AW         = 3;
  localparam int APB_DW         = 32;

  typedef enum logic [KIND_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic {
    REG_BLOCK_COUNT = 1'b0,
    REG_BLOCK_WORDS = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GEOM,
    ST_POP,
    ST_AMUL,
    ST_DIV,
    ST_FCHK,
    ST_DONE
  } back_state_t;

  typedef struct packed {
    op_t              op;
    logic             short_off;
    logic [OFF_W-1:0] rel_off;
  } req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] block_count;
    logic [WORDS_W-1:0] block_words;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/alc_if.sv -----
// ----------------------------------------------------------------------------
// Allocator channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface alc_in_if import alc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [OFF_W-1:0]  free_offset;

  modport source (output valid, output kind, output free_offset, input ready);
  modport sink (input valid, input kind, input free_offset, output ready);
endinterface

interface alc_out_if import alc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               ok;
  logic [OFF_W-1:0]   block_offset;
  logic [COUNT_W-1:0] free_count;

  modport source (output valid, output ok, output block_offset, output free_count,
                  input ready);
  modport sink (input valid, input ok, input block_offset, input free_count,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/fixed_block_free_list_allocator.sv -----
// ----------------------------------------------------------------------------
// Fixed block free list allocator
// Requests arrive on in_ch (kind: init, allocate, free, nop; free_offset for free).
// One result per request leaves on out_ch: ok, block_offset, free_count.
// Geometry is set over the APB port (block_count, block_words) and latched
// by an init request; write it only while no request is in flight.
// A request sits in a two-entry queue, then the engine executes it:
//   init computes the pool limit; allocate pops a freed block (one link RAM
//   read) or takes an untouched block, then forms the offset; free runs the
//   shift-subtract divider (one quotient bit per cycle, also for a misaligned
//   offset), then checks the remainder; other rejected requests go to DONE.
// The engine is the rate limiter; the queue keeps accepting while it works.
// The engine takes the next request only after the last result is loaded
// into the result register.
// The result register holds while out_ch.ready is low; the engine finishes
// the next request and waits, and the queue fills, then in_ch.ready drops.
// After reset the pool is empty: allocate fails and every free is rejected
// until the first init. The link RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_block_free_list_allocator import alc_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int WORD_BYTES = WORD_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  alc_in_if.sink                 in_ch,
  alc_out_if.source              out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  cfg_t cfg;
  req_t q_din;
  req_t q_dout;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;

  alc_cfg #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  alc_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_din  (q_din)
  );

  alc_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  alc_back #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .WORD_BYTES (WORD_BYTES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .head    (q_dout),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// ----- rtl/alc_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module alc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/alc_cfg.sv -----
// ----------------------------------------------------------------------------
// Allocator configuration registers
// APB-style register file holding the pool geometry for the next init.
// ----------------------------------------------------------------------------
`default_nettype none

module alc_cfg import alc_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  localparam logic [COUNT_W-1:0] COUNT_RST =
    COUNT_W'((MAX_BLOCKS < 256) ? MAX_BLOCKS : 256);

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [WORDS_W-1:0] words_r, words_nxt;
  reg_idx_t           idx;
  logic               wr_en;

  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    count_nxt = count_r;
    words_nxt = words_r;
    if (wr_en) begin
      unique case (idx)
        REG_BLOCK_COUNT: count_nxt = pwdata[COUNT_W-1:0];
        REG_BLOCK_WORDS: words_nxt = pwdata[WORDS_W-1:0];
        default:         count_nxt = count_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BLOCK_COUNT: prdata = APB_DW'(count_r);
      REG_BLOCK_WORDS: prdata = APB_DW'(words_r);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RST;
      words_r <= WORDS_W'(1);
    end else begin
      count_r <= count_nxt;
      words_r <= words_nxt;
    end
  end

  assign cfg.block_count = count_r;
  assign cfg.block_words = words_r;

endmodule

`default_nettype wire

// ----- rtl/alc_front.sv -----
// ----------------------------------------------------------------------------
// Allocator front end
// Accept requests, decode the kind and pre-compute the block distance.
// ----------------------------------------------------------------------------
`default_nettype none

module alc_front import alc_pkg::*; (
  alc_in_if.sink     in_ch,
  input  wire logic  q_full,
  output logic       q_push,
  output req_t       q_din
);

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    q_din.op        = op_t'(in_ch.kind);
    q_din.short_off = in_ch.free_offset < OFF_W'(HEADER_BYTES);
    q_din.rel_off   = in_ch.free_offset - OFF_W'(HEADER_BYTES);
  end

endmodule

`default_nettype wire

// ----- rtl/alc_fifo.sv -----
// ----------------------------------------------------------------------------
// Allocator request queue
// Short FIFO between the front end and the execution engine.
// ----------------------------------------------------------------------------
`default_nettype none

module alc_fifo import alc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire req_t din,
  output logic      full,
  input  wire logic pop,
  output req_t      dout,
  output logic      empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  req_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = cnt_r == CNT_W'(QUEUE_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/alc_back.sv -----
// ----------------------------------------------------------------------------
// Allocator execution engine
// Run init, allocate and free against the free list and drive results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module alc_back import alc_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int WORD_BYTES = WORD_BYTES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire req_t head,
  input  wire logic q_empty,
  output logic      q_pop,
  alc_out_if.source out_ch
);

  localparam int IDX_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int HEAD_W  = $clog2(MAX_BLOCKS + 1);
  localparam int BYTES_W = $clog2(WORDS_MAX * WORD_BYTES + 1);
  localparam int LIM_W   = HEAD_W + BYTES_W;
  localparam int REM_W   = IDX_W + BYTES_W + 1;
  localparam int STEP_W  = $clog2(IDX_W + 1);
  localparam int PROD_W  = IDX_W + BYTES_W + 1;
  localparam int OFFC_W  = (PROD_W > OFF_W) ? PROD_W : OFF_W;
  localparam int CMP_W   = (LIM_W > OFF_W) ? LIM_W : OFF_W;

  back_state_t        state_r, state_nxt;
  logic [HEAD_W-1:0]  stack_head_r, stack_head_nxt;
  logic [HEAD_W-1:0]  untouched_r, untouched_nxt;
  logic [HEAD_W-1:0]  free_total_r, free_total_nxt;
  logic [HEAD_W-1:0]  pool_blocks_r, pool_blocks_nxt;
  logic [BYTES_W-1:0] bytes_r, bytes_nxt;
  logic [LIM_W-1:0]   limit_r, limit_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [REM_W-1:0]   dsr_r, dsr_nxt;
  logic [IDX_W-1:0]   q_r, q_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               res_ok_r, res_ok_nxt;
  logic [OFF_W-1:0]   res_off_r, res_off_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic [OFF_W-1:0]   out_off_r, out_off_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  logic [COUNT_W-1:0] n_clamp;
  logic [WORDS_W-1:0] w_clamp;
  logic [OFFC_W-1:0]  off_full;
  logic               can_alloc;
  logic               from_list;
  logic               from_pool;
  logic               free_in_range;
  logic               div_ge;
  logic               out_load;

  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [HEAD_W-1:0]  ram_wdata, ram_rdata;

  alc_ram #(
    .WIDTH (HEAD_W),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (cfg.block_count == '0) begin
      n_clamp = COUNT_W'(1);
    end else if (int'(cfg.block_count) > MAX_BLOCKS) begin
      n_clamp = COUNT_W'(MAX_BLOCKS);
    end else begin
      n_clamp = cfg.block_count;
    end
    if (cfg.block_words == '0) begin
      w_clamp = WORDS_W'(1);
    end else if (int'(cfg.block_words) > WORDS_MAX) begin
      w_clamp = WORDS_W'(WORDS_MAX);
    end else begin
      w_clamp = cfg.block_words;
    end
  end

  assign can_alloc     = free_total_r != '0;
  assign from_list     = can_alloc && (stack_head_r != '0);
  assign from_pool     = can_alloc && (stack_head_r == '0) && (untouched_r < pool_blocks_r);
  assign free_in_range = !head.short_off && (CMP_W'(head.rel_off) < CMP_W'(limit_r));
  assign div_ge        = rem_r >= dsr_r;
  assign out_load      = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);
  assign off_full      = OFFC_W'(idx_r) * OFFC_W'(bytes_r) + OFFC_W'(HEADER_BYTES);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          unique case (head.op)
            OP_INIT:  state_nxt = ST_GEOM;
            OP_ALLOC: begin
              if (from_list) begin
                state_nxt = ST_POP;
              end else if (from_pool) begin
                state_nxt = ST_AMUL;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            OP_FREE:  state_nxt = free_in_range ? ST_DIV : ST_DONE;
            OP_NOP:   state_nxt = ST_DONE;
            default:  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_GEOM: state_nxt = ST_DONE;
      ST_POP:  state_nxt = ST_AMUL;
      ST_AMUL: state_nxt = ST_DONE;
      ST_DIV:  state_nxt = (step_r == STEP_W'(IDX_W - 1)) ? ST_FCHK : ST_DIV;
      ST_FCHK: state_nxt = ST_DONE;
      ST_DONE: state_nxt = out_load ? ST_IDLE : ST_DONE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    stack_head_nxt  = stack_head_r;
    untouched_nxt   = untouched_r;
    free_total_nxt  = free_total_r;
    pool_blocks_nxt = pool_blocks_r;
    bytes_nxt       = bytes_r;
    limit_nxt       = limit_r;
    idx_nxt         = idx_r;
    rem_nxt         = rem_r;
    dsr_nxt         = dsr_r;
    q_nxt           = q_r;
    step_nxt        = step_r;
    res_ok_nxt      = res_ok_r;
    res_off_nxt     = res_off_r;
    q_pop           = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = q_r;
    ram_wdata       = stack_head_r;
    ram_re          = 1'b0;
    ram_raddr       = IDX_W'(stack_head_r - 1'b1);

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          res_ok_nxt  = 1'b0;
          res_off_nxt = '0;
          unique case (head.op)
            OP_INIT: begin
              pool_blocks_nxt = HEAD_W'(n_clamp);
              bytes_nxt       = BYTES_W'(int'(w_clamp) * WORD_BYTES);
              stack_head_nxt  = '0;
              untouched_nxt   = '0;
              free_total_nxt  = HEAD_W'(n_clamp);
              res_ok_nxt      = 1'b1;
            end
            OP_ALLOC: begin
              if (from_list) begin
                ram_re  = 1'b1;
                idx_nxt = IDX_W'(stack_head_r - 1'b1);
              end else if (from_pool) begin
                idx_nxt        = IDX_W'(untouched_r);
                untouched_nxt  = untouched_r + 1'b1;
                free_total_nxt = free_total_r - 1'b1;
              end
            end
            OP_FREE: begin
              rem_nxt  = REM_W'(head.rel_off);
              dsr_nxt  = REM_W'(bytes_r) << (IDX_W - 1);
              q_nxt    = '0;
              step_nxt = '0;
            end
            OP_NOP:  res_ok_nxt = 1'b0;
            default: res_ok_nxt = 1'b0;
          endcase
        end
      end
      ST_GEOM: limit_nxt = LIM_W'(pool_blocks_r) * LIM_W'(bytes_r);
      ST_POP: begin
        stack_head_nxt = ram_rdata;
        free_total_nxt = free_total_r - 1'b1;
      end
      ST_AMUL: begin
        res_ok_nxt  = 1'b1;
        res_off_nxt = off_full[OFF_W-1:0];
      end
      ST_DIV: begin
        if (div_ge) begin
          rem_nxt = rem_r - dsr_r;
        end
        q_nxt    = IDX_W'({q_r, div_ge});
        dsr_nxt  = dsr_r >> 1;
        step_nxt = step_r + 1'b1;
      end
      ST_FCHK: begin
        if (rem_r == '0) begin
          ram_we         = 1'b1;
          stack_head_nxt = HEAD_W'(q_r) + 1'b1;
          if (free_total_r < pool_blocks_r) begin
            free_total_nxt = free_total_r + 1'b1;
          end
          res_ok_nxt = 1'b1;
        end
      end
      ST_DONE: res_ok_nxt = res_ok_r;
      default: res_ok_nxt = res_ok_r;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_off_nxt   = out_off_r;
    out_count_nxt = out_count_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_ok_nxt    = res_ok_r;
      out_off_nxt   = res_off_r;
      out_count_nxt = COUNT_W'(free_total_r);
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      stack_head_r  <= '0;
      untouched_r   <= '0;
      free_total_r  <= '0;
      pool_blocks_r <= '0;
      bytes_r       <= BYTES_W'(WORD_BYTES);
      limit_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      stack_head_r  <= stack_head_nxt;
      untouched_r   <= untouched_nxt;
      free_total_r  <= free_total_nxt;
      pool_blocks_r <= pool_blocks_nxt;
      bytes_r       <= bytes_nxt;
      limit_r       <= limit_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    rem_r       <= rem_nxt;
    dsr_r       <= dsr_nxt;
    q_r         <= q_nxt;
    step_r      <= step_nxt;
    res_ok_r    <= res_ok_nxt;
    res_off_r   <= res_off_nxt;
    out_ok_r    <= out_ok_nxt;
    out_off_r   <= out_off_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.ok           = out_ok_r;
  assign out_ch.block_offset = out_off_r;
  assign out_ch.free_count   = out_count_r;

  `ASSERT_RST(a_total_bound, free_total_r <= pool_blocks_r)
  `ASSERT_RST(a_head_bound, stack_head_r <= pool_blocks_r)
  `ASSERT_RST(a_untouched_bound, untouched_r <= pool_blocks_r)
  `ASSERT_NEXT(a_push_sets_head, state_r == ST_FCHK && rem_r == '0, stack_head_r != '0)

endmodule

`default_nettype wire

// ----- tb/fixed_block_free_list_allocator_tb.sv -----
// ----------------------------------------------------------------------------
// Fixed block free list allocator testbench
// Drives init, allocate, free and idle requests through the request channel
// under several pool geometries written over APB. A scoreboard predicts each
// result from its own model of the free list and checks every field of every
// result in order. Both channels idle at random, and the result side holds
// off once long enough to back up the request side.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_block_free_list_allocator_tb import alc_pkg::*; ();

  typedef struct packed {
    logic               ok;
    logic [OFF_W-1:0]   offset;
    logic [COUNT_W-1:0] count;
  } alloc_result_t;

  class alloc_scoreboard;
    logic [COUNT_W-1:0] cfg_count;
    logic [WORDS_W-1:0] cfg_words;
    int unsigned        list_top;
    int unsigned        untouched;
    int unsigned        free_total;
    int unsigned        pool_blocks;
    int unsigned        pool_words;
    logic [COUNT_W-1:0] links [MAX_BLOCKS_DEF];
    alloc_result_t      expected_q [$];
    int                 errors;

    function new();
      cfg_count   = COUNT_W'(MAX_BLOCKS_DEF);
      cfg_words   = WORDS_W'(1);
      list_top    = 0;
      untouched   = 0;
      free_total  = 0;
      pool_blocks = 0;
      pool_words  = 1;
      errors      = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int unsigned block_bytes();
      return pool_words * WORD_BYTES_DEF;
    endfunction

    function void write_reg(reg_idx_t idx, logic [APB_DW-1:0] val);
      if (idx == REG_BLOCK_COUNT) begin
        cfg_count = val[COUNT_W-1:0];
      end else begin
        cfg_words = val[WORDS_W-1:0];
      end
    endfunction

    function void note_request(op_t op, logic [OFF_W-1:0] off);
      alloc_result_t res;
      int unsigned   idx;
      int unsigned   rel;
      bit            got;
      res = '0;
      got = 0;
      idx = 0;
      case (op)
        OP_INIT: begin
          pool_blocks = (cfg_count < 1) ? 1 :
                        (cfg_count > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : cfg_count;
          pool_words  = (cfg_words < 1) ? 1 : (cfg_words > WORDS_MAX) ? WORDS_MAX : cfg_words;
          list_top    = 0;
          untouched   = 0;
          free_total  = pool_blocks;
          res.ok      = 1'b1;
        end
        OP_ALLOC: begin
          if (free_total != 0) begin
            if (list_top != 0) begin
              idx      = (list_top - 1) % MAX_BLOCKS_DEF;
              list_top = links[idx];
              got      = 1;
            end else if (untouched < pool_blocks) begin
              idx       = untouched;
              untouched = untouched + 1;
              got       = 1;
            end
            if (got) begin
              free_total = free_total - 1;
              res.ok     = 1'b1;
              res.offset = OFF_W'(HEADER_BYTES + idx * block_bytes());
            end
          end
        end
        OP_FREE: begin
          if (off >= HEADER_BYTES) begin
            rel = off - HEADER_BYTES;
            if (rel % block_bytes() == 0) begin
              idx = rel / block_bytes();
              if (idx < pool_blocks) begin
                links[idx] = COUNT_W'(list_top);
                list_top   = idx + 1;
                if (free_total < pool_blocks) free_total = free_total + 1;
                res.ok = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
      res.count = COUNT_W'(free_total);
      expected_q.push_back(res);
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(logic ok, logic [OFF_W-1:0] offset, logic [COUNT_W-1:0] count);
      alloc_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result, offset", offset, 0);
      end else begin
        want = expected_q.pop_front();
        if (ok !== want.ok) report_mismatch("ok", ok, want.ok);
        if (offset !== want.offset) report_mismatch("block_offset", offset, want.offset);
        if (count !== want.count) report_mismatch("free_count", count, want.count);
      end
    endtask
  endclass

  localparam int SETTLE      = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 125;
  localparam int HOLD_CYCLES = 300;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  bit                calm;
  bit                hold_request;
  int                hold_left;
  int                stall_cycles;

  alloc_scoreboard   sb = new();

  alc_in_if  in_if ();
  alc_out_if out_if ();

  fixed_block_free_list_allocator dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_request) begin
      hold_request = 0;
      out_if.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
    end else begin
      out_if.ready <= calm || ($urandom_range(99) >= 15);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_result(out_if.ok, out_if.block_offset, out_if.free_count);
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("fixed_block_free_list_allocator_tb failed");
    $finish;
  end

  task automatic send_request(op_t op, logic [OFF_W-1:0] off);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 15) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.kind        <= op;
    in_if.free_offset <= off;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(op, off);
  endtask

  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [APB_DW-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(4 * int'(idx));
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  function automatic logic [OFF_W-1:0] pick_free_offset();
    int unsigned sel;
    int unsigned idx;
    int unsigned bytes;
    sel   = $urandom_range(9);
    bytes = sb.block_bytes();
    idx   = 0;
    if (sb.pool_blocks == 0 || sel == 9) return OFF_W'($urandom);
    if (sel < 6 && sb.untouched > 0) begin
      idx = $urandom_range(sb.untouched - 1);
    end else if (sel < 8) begin
      idx = $urandom_range(sb.pool_blocks - 1);
    end else begin
      idx = sb.pool_blocks + $urandom_range(3);
    end
    if (sel == 7) return OFF_W'(HEADER_BYTES + idx * bytes + $urandom_range(1, bytes - 1));
    return OFF_W'(HEADER_BYTES + idx * bytes);
  endfunction

  task automatic random_request();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) begin
      send_request(OP_NOP, OFF_W'($urandom));
    end else if (r < 8) begin
      send_request(OP_INIT, OFF_W'($urandom));
    end else if (r < 52) begin
      send_request(OP_ALLOC, OFF_W'($urandom));
    end else begin
      send_request(OP_FREE, pick_free_offset());
    end
  endtask

  initial begin
    logic [COUNT_W-1:0] cnt;
    logic [WORDS_W-1:0] wd;
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.kind        = OP_NOP;
    in_if.free_offset = '0;
    out_if.ready      = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    calm              = 0;
    hold_request      = 0;
    hold_left         = 0;
    stall_cycles      = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // empty pool before the first init
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 17'd8);
    send_request(OP_NOP, '0);
    drain();
    write_reg(REG_BLOCK_COUNT, 3);
    write_reg(REG_BLOCK_WORDS, 2);
    send_request(OP_INIT, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 17'd24);
    send_request(OP_FREE, 17'd24);
    send_request(OP_FREE, 17'd7);
    send_request(OP_FREE, 17'd9);
    send_request(OP_FREE, 17'd56);
    send_request(OP_FREE, 17'h1FFFF);
    send_request(OP_FREE, 17'd8);
    send_request(OP_FREE, 17'd40);
    // count runs dry while the list still holds a duplicate
    repeat (5) send_request(OP_ALLOC, '0);
    send_request(OP_NOP, 17'h1FFFF);
    send_request(OP_INIT, '0);
    send_request(OP_ALLOC, '0);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: begin
          cnt = COUNT_W'(1);
          wd  = WORDS_W'(1);
        end
        1: begin
          cnt = COUNT_W'(256);
          wd  = WORDS_W'(64);
        end
        2: begin
          cnt = COUNT_W'(511);
          wd  = WORDS_W'(127);
        end
        3: begin
          cnt = '0;
          wd  = '0;
        end
        default: begin
          cnt = (phase == PHASES - 1) ? COUNT_W'($urandom_range(1, 256)) :
                                        COUNT_W'($urandom_range(2, 12));
          wd  = WORDS_W'($urandom_range(1, 64));
        end
      endcase
      write_reg(REG_BLOCK_COUNT, cnt);
      write_reg(REG_BLOCK_WORDS, wd);
      calm         = (phase == 2);
      hold_request = (phase == 1);
      send_request(OP_INIT, OFF_W'($urandom));
      repeat (PHASE_ITEMS) random_request();
    end
    calm = 0;
    drain();

    if (sb.errors == 0) begin
      $display("fixed_block_free_list_allocator_tb passed");
    end else begin
      $display("fixed_block_free_list_allocator_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- fixed_block_free_list_allocator.f -----
+incdir+rtl
rtl/alc_pkg.sv
rtl/alc_if.sv
rtl/alc_ram.sv
rtl/alc_cfg.sv
rtl/alc_front.sv
rtl/alc_fifo.sv
rtl/alc_back.sv
rtl/fixed_block_free_list_allocator.sv
tb/fixed_block_free_list_allocator_tb.sv
